### sv/assert_macros.svh
// Assertion helpers used by the checker file.
// Both expect clk and rst_n in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/wwt_pkg.sv
// ----------------------------------------------------------------------------
// wwt_pkg
// Types, widths and defaults for the waypoint window tracker.
// ----------------------------------------------------------------------------
package wwt_pkg;

  localparam int ID_W = 63;
  localparam int CMD_W = 2;
  localparam int SLOT_W = 4;
  localparam int IN_DATA_W = 256;
  localparam int OUT_DATA_W = 200;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int WINDOW_LENGTH_DEF = 15;
  localparam int CHECK_SPAN_DEF = 10;

  localparam logic [ID_W-1:0] HOME_RST = 63'd17554;
  localparam logic [ID_W-1:0] START_CID_RST = 63'd101;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_ENTRY  = 2'd1,
    CMD_REPORT = 2'd2,
    CMD_HOME   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_HOME      = 1'b0,
    REG_START_CID = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

### sv/wwt_ram.sv
// ----------------------------------------------------------------------------
// wwt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/waypoint_window_tracker_unit.sv
// ----------------------------------------------------------------------------
// waypoint_window_tracker_unit
// Waypoint chain table with span check and window emission.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | content
//  in_     | in  | tvalid/tready      | command, plan entry, report
//  out_    | out | tvalid/tready      | one window slot per transaction
//  cfg_    | in  | we                 | home id, start command id
//
// One input transaction at a time; in_tready is high only when idle.
// A scan of the table makes one read of the RAM per cycle.
// A report walks up to CHECK_SPAN scans.
// A window emits WINDOW_LENGTH slots; outside home mode a table scan finds each valid slot.
// Reset is synchronous; the table RAM is not cleared. out_tready stalls emission.
module waypoint_window_tracker_unit #(
  parameter int TABLE_DEPTH   = wwt_pkg::TABLE_DEPTH_DEF,
  parameter int WINDOW_LENGTH = wwt_pkg::WINDOW_LENGTH_DEF,
  parameter int CHECK_SPAN    = wwt_pkg::CHECK_SPAN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // command[1:0], first_waypoint[64:2], entry_id[127:65], entry_next[190:128],
  // reported_waypoint[253:191], zero fill
  input  logic [wwt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,   // entry_last
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // command_id[62:0], window_first[125:63], slot[129:126], waypoint_id[192:130],
  // slot_valid[193], zero fill
  output logic [wwt_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                           out_tlast,  // last
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wwt_pkg::ID_W-1:0]       cfg_wdata
);
  import wwt_pkg::*;

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int HW  = (CHECK_SPAN > 1) ? $clog2(CHECK_SPAN) : 1;
  localparam int SCW = ($clog2(WINDOW_LENGTH) > SLOT_W) ? $clog2(WINDOW_LENGTH) : SLOT_W;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt, idx_r, idx_nxt;
  logic plan_valid_r, plan_valid_nxt, home_mode_r, home_mode_nxt;
  logic [ID_W-1:0] pend_first_r, pend_first_nxt, cur_r, cur_nxt;
  logic [ID_W-1:0] home_r, home_nxt, ncid_r, ncid_nxt, cid_r, cid_nxt;
  logic [ID_W-1:0] key_r, key_nxt, rep_r, rep_nxt, em_wp_r, em_wp_nxt;
  logic em_valid_r, em_valid_nxt, pend_r, pend_nxt, span_mode_r, span_mode_nxt;
  logic [HW-1:0] hops_r, hops_nxt;
  logic [SCW-1:0] slot_r, slot_nxt;

  logic out_valid_r, out_valid_nxt, out_sv_r, out_sv_nxt, out_last_r, out_last_nxt;
  logic [ID_W-1:0] out_cid_r, out_cid_nxt, out_first_r, out_first_nxt;
  logic [ID_W-1:0] out_wp_r, out_wp_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;

  logic ram_we, ram_re, hit, win_go, in_acc, out_free;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [2*ID_W-1:0] ram_wdata, ram_rdata;
  logic [ID_W-1:0] rd_id, rd_next, win_base;
  cmd_t in_cmd;
  logic [ID_W-1:0] in_first, in_eid, in_enext, in_rep;

  assign in_cmd   = cmd_t'(in_tdata[1:0]);
  assign in_first = in_tdata[64:2];
  assign in_eid   = in_tdata[127:65];
  assign in_enext = in_tdata[190:128];
  assign in_rep   = in_tdata[253:191];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign rd_id   = ram_rdata[ID_W-1:0];
  assign rd_next = ram_rdata[2*ID_W-1:ID_W];
  assign hit     = pend_r && (rd_id == key_r);

  // Writes happen only in idle and reads only in scan, so no forwarding.
  assign ram_waddr = count_r[AW-1:0];
  assign ram_wdata = {in_enext, in_eid};
  assign ram_raddr = idx_r[AW-1:0];
  assign ram_re    = (state_r == ST_SCAN) && (idx_r < count_r) && !hit;

  wwt_ram #(
    .WIDTH(2 * ID_W),
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    plan_valid_nxt = plan_valid_r;
    home_mode_nxt  = home_mode_r;
    pend_first_nxt = pend_first_r;
    cur_nxt        = cur_r;
    home_nxt       = home_r;
    ncid_nxt       = ncid_r;
    cid_nxt        = cid_r;
    key_nxt        = key_r;
    rep_nxt        = rep_r;
    em_wp_nxt      = em_wp_r;
    em_valid_nxt   = em_valid_r;
    pend_nxt       = 1'b0;
    span_mode_nxt  = span_mode_r;
    hops_nxt       = hops_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cid_nxt    = out_cid_r;
    out_first_nxt  = out_first_r;
    out_slot_nxt   = out_slot_r;
    out_wp_nxt     = out_wp_r;
    out_sv_nxt     = out_sv_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    win_go         = 1'b0;
    win_base       = '0;

    if (cfg_we) begin
      if (reg_idx_t'(cfg_index) == REG_HOME) begin
        home_nxt = cfg_wdata;
      end else begin
        ncid_nxt = cfg_wdata;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_BEGIN: begin
              count_nxt      = '0;
              plan_valid_nxt = 1'b0;
              pend_first_nxt = in_first;
            end
            CMD_ENTRY: begin
              if (count_r < CW'(TABLE_DEPTH)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CW'(1);
              end
              if (in_tlast) begin
                plan_valid_nxt = 1'b1;
                win_go         = 1'b1;
                win_base       = pend_first_r;
              end
            end
            CMD_REPORT: begin
              if (plan_valid_r && (in_rep != '0)) begin
                if (home_mode_r) begin
                  if (in_rep != home_r) begin
                    win_go   = 1'b1;
                    win_base = home_r;
                  end
                end else begin
                  key_nxt       = cur_r;
                  rep_nxt       = in_rep;
                  hops_nxt      = '0;
                  idx_nxt       = '0;
                  span_mode_nxt = 1'b1;
                  state_nxt     = ST_SCAN;
                end
              end
            end
            CMD_HOME: begin
              home_mode_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          if (span_mode_r) begin
            if (key_r == rep_r) begin
              state_nxt = ST_IDLE;
            end else if (hops_r == HW'(CHECK_SPAN - 1)) begin
              win_go   = 1'b1;
              win_base = rep_r;
            end else begin
              key_nxt  = rd_next;
              hops_nxt = hops_r + HW'(1);
              idx_nxt  = '0;
            end
          end else begin
            em_wp_nxt    = key_r;
            em_valid_nxt = 1'b1;
            key_nxt      = rd_next;
            state_nxt    = ST_EMIT;
          end
        end else if (ram_re) begin
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
        end else if (!pend_r) begin
          if (span_mode_r) begin
            win_go   = 1'b1;
            win_base = rep_r;
          end else begin
            em_wp_nxt    = '0;
            em_valid_nxt = 1'b0;
            state_nxt    = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_cid_nxt   = cid_r;
          out_first_nxt = cur_r;
          out_slot_nxt  = slot_r[SLOT_W-1:0];
          out_wp_nxt    = em_wp_r;
          out_sv_nxt    = em_valid_r;
          out_last_nxt  = (slot_r == SCW'(WINDOW_LENGTH - 1));
          slot_nxt      = slot_r + SCW'(1);
          if (slot_r == SCW'(WINDOW_LENGTH - 1)) begin
            state_nxt = ST_IDLE;
          end else if (!home_mode_r && em_valid_r) begin
            idx_nxt   = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (win_go) begin
      cur_nxt   = win_base;
      state_nxt = ST_IDLE;
      if (win_base != '0) begin
        cid_nxt       = ncid_r;
        ncid_nxt      = ncid_r + ID_W'(1);
        slot_nxt      = '0;
        span_mode_nxt = 1'b0;
        if (home_mode_r) begin
          cur_nxt      = home_r;
          em_wp_nxt    = home_r;
          em_valid_nxt = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          key_nxt   = win_base;
          idx_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      plan_valid_r <= 1'b0;
      home_mode_r  <= 1'b0;
      pend_first_r <= '0;
      cur_r        <= '0;
      home_r       <= HOME_RST;
      ncid_r       <= START_CID_RST;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      plan_valid_r <= plan_valid_nxt;
      home_mode_r  <= home_mode_nxt;
      pend_first_r <= pend_first_nxt;
      cur_r        <= cur_nxt;
      home_r       <= home_nxt;
      ncid_r       <= ncid_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    cid_r       <= cid_nxt;
    key_r       <= key_nxt;
    rep_r       <= rep_nxt;
    em_wp_r     <= em_wp_nxt;
    em_valid_r  <= em_valid_nxt;
    span_mode_r <= span_mode_nxt;
    hops_r      <= hops_nxt;
    slot_r      <= slot_nxt;
    out_cid_r   <= out_cid_nxt;
    out_first_r <= out_first_nxt;
    out_slot_r  <= out_slot_nxt;
    out_wp_r    <= out_wp_nxt;
    out_sv_r    <= out_sv_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {6'd0, out_sv_r, out_wp_r, out_slot_r, out_first_r, out_cid_r};

endmodule

### sv/wwt_checker.sv
// ----------------------------------------------------------------------------
// wwt_checker
// Port-level checks for the waypoint window tracker.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wwt_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [wwt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  `AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `AST_IMPL(a_busy_mid_window, out_tvalid && !out_tlast, !in_tready)
  `AST_NEXT(a_cid_steady, out_tvalid && out_tready && !out_tlast, $stable(out_tdata[62:0]))
  `AST_NEXT(a_break_sticks, out_tvalid && out_tready && !out_tlast && !out_tdata[193],
            !out_tdata[193])

endmodule

bind waypoint_window_tracker_unit wwt_checker u_wwt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

### verif/tb_waypoint_window_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_waypoint_window_tracker_unit
// Self-checking bench for the waypoint window tracker: a software copy of the
// table, chain walk and window emission predicts every window slot, which is
// compared field by field against the out_ stream under random flow control.
// ----------------------------------------------------------------------------
module tb_waypoint_window_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import wwt_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int WLEN = WINDOW_LENGTH_DEF;
  localparam int SPAN = CHECK_SPAN_DEF;
  localparam longint LIMIT = 4000000;

  typedef logic [ID_W-1:0] wid_t;

  typedef struct packed {
    cmd_t cmd;
    wid_t first;
    wid_t eid;
    wid_t enext;
    logic elast;
    wid_t rep;
  } item_t;

  typedef struct packed {
    wid_t cid;
    wid_t wfirst;
    logic [SLOT_W-1:0] slot;
    wid_t wp;
    logic valid;
    logic last;
  } slot_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_we = 0;
  logic cfg_index = 0;
  wid_t cfg_wdata = '0;

  waypoint_window_tracker_unit DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  wid_t home_id, next_cid, pend_first, cur_wp;
  wid_t ids[DEPTH];
  wid_t nexts[DEPTH];
  int n_entries;
  bit plan_ok, homing;

  item_t pending_items[$];
  slot_t expected_slots[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 0;
  int in_gap = 0, out_gap = 0;
  bit in_taken = 0, out_taken = 0;

  // plan model kept by the stimulus to build reachable reports
  wid_t plan_ids[$];

  function automatic int find_entry(wid_t id);
    for (int i = 0; i < n_entries; i++)
      if (ids[i] == id) return i;
    return -1;
  endfunction

  function automatic bit near_current(wid_t id);
    wid_t nid;
    int p;
    nid = cur_wp;
    for (int h = 0; h < SPAN; h++) begin
      p = find_entry(nid);
      if (p < 0) return 0;
      if (ids[p] == id) return 1;
      nid = nexts[p];
    end
    return 0;
  endfunction

  task automatic emit_window();
    wid_t cid, nid;
    bit ok;
    int p;
    slot_t s;
    if (cur_wp == 0) return;
    cid = next_cid;
    next_cid = next_cid + 1;
    if (homing) cur_wp = home_id;
    nid = cur_wp;
    ok = 1;
    for (int i = 0; i < WLEN; i++) begin
      s = '0;
      s.cid = cid;
      s.wfirst = cur_wp;
      s.slot = i[SLOT_W-1:0];
      s.last = (i == WLEN - 1);
      if (homing) begin
        s.wp = home_id;
        s.valid = 1;
      end else begin
        p = ok ? find_entry(nid) : -1;
        if (p >= 0) begin
          s.wp = ids[p];
          nid = nexts[p];
        end else ok = 0;
        s.valid = ok;
      end
      expected_slots.push_back(s);
    end
  endtask

  task automatic predict_windows(item_t it);
    case (it.cmd)
      CMD_BEGIN: begin
        n_entries = 0;
        plan_ok = 0;
        pend_first = it.first;
      end
      CMD_ENTRY: begin
        if (n_entries < DEPTH) begin
          ids[n_entries] = it.eid;
          nexts[n_entries] = it.enext;
          n_entries++;
        end
        if (it.elast) begin
          plan_ok = 1;
          cur_wp = pend_first;
          emit_window();
        end
      end
      CMD_REPORT: begin
        if (plan_ok && it.rep != 0) begin
          if (homing) begin
            if (it.rep != home_id) begin
              cur_wp = home_id;
              emit_window();
            end
          end else if (!near_current(it.rep)) begin
            cur_wp = it.rep;
            emit_window();
          end
        end
      end
      default: homing = 1;
    endcase
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sample handshakes at the accepting edge
  always @(posedge clk) begin
    in_taken = rst_n && in_tvalid && in_tready;
    out_taken = rst_n && out_tvalid && out_tready;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        predict_windows(pending_items.pop_front());
        in_gap = $urandom_range(0, 14);
        if ($urandom_range(0, 2) == 0) in_gap = 0;
      end
      if (in_tvalid && !in_taken) begin
      end else if (in_gap > 0) begin
        in_tvalid <= 0;
        in_gap--;
      end else if (pending_items.size() > 0) begin
        in_tvalid <= 1;
        in_tdata <= {2'b0, pending_items[0].rep, pending_items[0].enext,
                     pending_items[0].eid, pending_items[0].first, pending_items[0].cmd};
        in_tlast <= pending_items[0].elast;
      end else in_tvalid <= 0;
      if (hold_off) out_tready <= 0;
      else if (out_gap > 0) begin
        out_tready <= 0;
        out_gap--;
      end else begin
        out_tready <= 1;
        if (out_taken) begin
          out_gap = $urandom_range(0, 14);
          if ($urandom_range(0, 2) == 0) out_gap = 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    slot_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.cid = out_tdata[62:0];
      got.wfirst = out_tdata[125:63];
      got.slot = out_tdata[129:126];
      got.wp = out_tdata[192:130];
      got.valid = out_tdata[193];
      got.last = out_tlast;
      if (expected_slots.size() == 0) begin
        $display("%0t unexpected slot: actual %p", $time, got);
        errors++;
      end else begin
        want = expected_slots.pop_front();
        if (got.cid !== want.cid)
          $display("%0t command_id exp %0d act %0d", $time, want.cid, got.cid);
        if (got.wfirst !== want.wfirst)
          $display("%0t window_first exp %0d act %0d", $time, want.wfirst, got.wfirst);
        if (got.slot !== want.slot)
          $display("%0t slot exp %0d act %0d", $time, want.slot, got.slot);
        if (got.wp !== want.wp)
          $display("%0t waypoint_id exp %0d act %0d", $time, want.wp, got.wp);
        if (got.valid !== want.valid)
          $display("%0t slot_valid exp %0b act %0b", $time, want.valid, got.valid);
        if (got.last !== want.last)
          $display("%0t last exp %0b act %0b", $time, want.last, got.last);
        if (got !== want) errors++;
      end
    end
  end

  function automatic wid_t rand_id();
    wid_t v;
    v = wid_t'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: return v;
      1: return '1 - wid_t'($urandom_range(0, 3));
      default: return wid_t'($urandom_range(1, 40));
    endcase
  endfunction

  task automatic push(cmd_t c, wid_t a, wid_t b, wid_t n, logic l, wid_t r);
    item_t it;
    it.cmd = c;
    it.first = a;
    it.eid = b;
    it.enext = n;
    it.elast = l;
    it.rep = r;
    pending_items.push_back(it);
  endtask

  // Well-formed plan: chain of ids that loops back to its first id, sometimes broken midway.
  task automatic push_plan(int len, bit broken);
    wid_t base;
    plan_ids.delete();
    base = ($urandom_range(0, 3) == 0) ? rand_id() : wid_t'($urandom_range(1, 200));
    for (int i = 0; i < len; i++) plan_ids.push_back(base + wid_t'(i));
    push(CMD_BEGIN, plan_ids[0], rand_id(), rand_id(), 1'($urandom), rand_id());
    for (int i = 0; i < len; i++)
      push(CMD_ENTRY, rand_id(), plan_ids[i],
           (broken && i == len / 2) ? rand_id() : plan_ids[(i + 1) % len],
           i == len - 1, rand_id());
  endtask

  task automatic write_reg(reg_idx_t idx, wid_t val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == REG_HOME) home_id = val;
    else next_cid = val;
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || expected_slots.size() > 0)
      @(posedge clk);
    repeat (SPAN * (DEPTH + 2) + 50) @(posedge clk);
  endtask

  task automatic reset_model();
    home_id = HOME_RST;
    next_cid = START_CID_RST;
    n_entries = 0;
    plan_ok = 0;
    homing = 0;
    pend_first = 0;
    cur_wp = 0;
  endtask

  initial begin
    int n, k;
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: report without plan, window at zero, full table, loop, extremes
    push(CMD_REPORT, 0, 0, 0, 0, 5);
    push(CMD_BEGIN, 0, 0, 0, 0, 0);
    push(CMD_ENTRY, '1, 7, 8, 1, '1);
    push(CMD_REPORT, 0, 0, 0, 0, 0);
    push(CMD_BEGIN, '1, '1, '1, 1, '1);
    push(CMD_ENTRY, 0, '1, 1, 0, 0);
    push(CMD_ENTRY, 0, 1, '1, 1, 0);
    push(CMD_REPORT, 0, 0, 0, 0, 1);
    push(CMD_REPORT, 0, 0, 0, 0, 3);
    push(CMD_ENTRY, 0, 3, 9, 1, 0);
    push_plan(12, 0);
    push(CMD_REPORT, 0, 0, 0, 0, plan_ids[5]);
    push(CMD_REPORT, 0, 0, 0, 0, plan_ids[11]);
    drain();
    write_reg(REG_START_CID, '1);
    push_plan(DEPTH, 0);
    push(CMD_ENTRY, 0, 900, 901, 1, 0);
    push(CMD_REPORT, 0, 0, 0, 0, plan_ids[40]);
    drain();
    write_reg(REG_HOME, '1);
    write_reg(REG_START_CID, 0);

    // long receiver stall while inputs keep coming
    push_plan(6, 1);
    push(CMD_REPORT, 0, 0, 0, 0, 555);
    push(CMD_REPORT, 0, 0, 0, 0, 556);
    hold_off = 1;
    repeat (600) @(posedge clk);
    hold_off = 0;
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      n = 0;
      while (n < 75) begin
        k = $urandom_range(0, 9);
        if (k < 2) begin
          push_plan($urandom_range(1, 16), $urandom_range(0, 3) == 0);
          n += plan_ids.size() + 1;
        end else if (k < 8 && plan_ids.size() > 0) begin
          push(CMD_REPORT, rand_id(), rand_id(), rand_id(), 1'($urandom),
               ($urandom_range(0, 3) == 0) ? rand_id()
               : plan_ids[$urandom_range(0, plan_ids.size() - 1)]);
          n++;
        end else if (k == 8) begin
          push(($urandom_range(0, 1) == 0) ? CMD_REPORT : CMD_ENTRY,
               rand_id(), rand_id(), rand_id(), 0, rand_id());
          n++;
        end else begin
          push(CMD_REPORT, 0, 0, 0, 0, 0);
          n++;
        end
      end
      if (ph == 2) begin
        push(CMD_HOME, rand_id(), rand_id(), rand_id(), 1'($urandom), rand_id());
        push(CMD_REPORT, 0, 0, 0, 0, home_id);
        for (int i = 0; i < 10; i++)
          push(CMD_REPORT, 0, 0, 0, 0, rand_id());
        push_plan(4, 0);
      end
      drain();
      if (ph == 0) begin
        write_reg(REG_HOME, 1);
        write_reg(REG_START_CID, '1 - 3);
      end else if (ph == 1) write_reg(REG_HOME, rand_id() | 1);
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

### sim.f
+incdir+sv
sv/wwt_pkg.sv
sv/wwt_ram.sv
sv/waypoint_window_tracker_unit.sv
sv/wwt_checker.sv
verif/tb_waypoint_window_tracker_unit.sv
